/* src/u8fd_pkg.sv */
// Shared types and constants for the 8N1 UART.
package u8fd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] period_t;
  typedef logic [16:0] rx_time_t;
  typedef logic [9:0]  tx_frame_t;
  typedef logic [3:0]  bit_count_t;

  localparam period_t    BIT_PERIOD_RESET = 16'd104;
  localparam bit_count_t TX_FRAME_BITS    = 4'd10;
  localparam bit_count_t RX_DATA_BITS     = 4'd8;

endpackage

/* src/u8fd_in_if.sv */
// Input channel: one tick word with receive line sample and send request.
interface u8fd_in_if;
  import u8fd_pkg::*;

  logic  valid;
  logic  ready;
  logic  rx_line;
  logic  send_request;
  byte_t send_byte;

  modport source (output valid, output rx_line, output send_request, output send_byte,
                  input ready);
  modport sink   (input valid, input rx_line, input send_request, input send_byte,
                  output ready);
endinterface

/* src/u8fd_out_if.sv */
// Result channel: one status word per tick.
interface u8fd_out_if;
  import u8fd_pkg::*;

  logic  valid;
  logic  ready;
  logic  tx_line;
  logic  tx_busy;
  logic  send_accepted;
  logic  rx_valid;
  byte_t rx_byte;

  modport source (output valid, output tx_line, output tx_busy, output send_accepted,
                  output rx_valid, output rx_byte, input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input send_accepted,
                  input rx_valid, input rx_byte, output ready);
endinterface

/* src/uart_8n1_full_duplex.sv */
// Full-duplex 8N1 UART where each input word is one bit-timer tick and yields one
// status word. A word is taken in every cycle in which the output register is empty
// or being read, so the block sustains one tick per clock; the result of a tick
// appears in the output register in the cycle after the word is taken, computed by
// the transmit and receive timer updates in a single pass. Program cfg_wdata with
// the number of ticks per bit (reset 104) while no tick is in flight.
module uart_8n1_full_duplex (
  input  logic              clk,
  input  logic              rst_n,
  u8fd_in_if.sink           in_if,
  u8fd_out_if.source        out_if,
  input  logic              cfg_we,
  input  u8fd_pkg::period_t cfg_wdata
);
  import u8fd_pkg::*;

  period_t    bit_period_r;

  tx_frame_t  tx_shift_r, tx_shift_nxt;
  bit_count_t tx_bits_left_r, tx_bits_left_nxt;
  period_t    tx_timer_r, tx_timer_nxt;
  logic       tx_level_r, tx_level_nxt;
  logic       tx_active_r, tx_active_nxt;
  logic       accepted_nxt;

  logic       rx_sampling_r, rx_sampling_nxt;
  rx_time_t   rx_timer_r, rx_timer_nxt;
  byte_t      rx_shift_r, rx_shift_nxt;
  bit_count_t rx_bits_left_r, rx_bits_left_nxt;
  logic       rx_prev_level_r, rx_prev_level_nxt;
  logic       rx_valid_nxt;
  byte_t      rx_byte_nxt;

  logic       out_valid_r;
  logic       tx_line_r, tx_busy_r, send_accepted_r, rx_valid_r;
  byte_t      rx_byte_r;

  logic       take;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    tx_shift_nxt     = tx_shift_r;
    tx_bits_left_nxt = tx_bits_left_r;
    tx_timer_nxt     = tx_timer_r;
    tx_level_nxt     = tx_level_r;
    tx_active_nxt    = tx_active_r;
    accepted_nxt     = 1'b0;
    if (tx_active_r) begin
      if (tx_timer_r > 16'd1) begin
        tx_timer_nxt = tx_timer_r - 16'd1;
      end else if (tx_bits_left_r == 4'd0) begin
        tx_active_nxt    = 1'b0;
        tx_bits_left_nxt = TX_FRAME_BITS;
        tx_level_nxt     = 1'b1;
      end else begin
        tx_level_nxt     = tx_shift_r[0];
        tx_shift_nxt     = {1'b0, tx_shift_r[9:1]};
        tx_bits_left_nxt = tx_bits_left_r - 4'd1;
        tx_timer_nxt     = bit_period_r;
      end
    end
    if (in_if.send_request && !tx_active_nxt) begin
      tx_shift_nxt     = {1'b1, in_if.send_byte, 1'b0};
      tx_bits_left_nxt = TX_FRAME_BITS;
      tx_timer_nxt     = bit_period_r;
      tx_level_nxt     = 1'b1;
      tx_active_nxt    = 1'b1;
      accepted_nxt     = 1'b1;
    end
  end

  always_comb begin
    rx_sampling_nxt   = rx_sampling_r;
    rx_timer_nxt      = rx_timer_r;
    rx_shift_nxt      = rx_shift_r;
    rx_bits_left_nxt  = rx_bits_left_r;
    rx_valid_nxt      = 1'b0;
    rx_byte_nxt       = 8'd0;
    rx_prev_level_nxt = in_if.rx_line;
    if (rx_sampling_r) begin
      if (rx_timer_r > 17'd1) begin
        rx_timer_nxt = rx_timer_r - 17'd1;
      end else begin
        rx_shift_nxt     = {in_if.rx_line, rx_shift_r[7:1]};
        rx_bits_left_nxt = rx_bits_left_r - 4'd1;
        if (rx_bits_left_nxt == 4'd0) begin
          rx_bits_left_nxt = RX_DATA_BITS;
          rx_sampling_nxt  = 1'b0;
          rx_valid_nxt     = 1'b1;
          rx_byte_nxt      = rx_shift_nxt;
        end else begin
          rx_timer_nxt = {1'b0, bit_period_r};
        end
      end
    end else if (rx_prev_level_r && !in_if.rx_line) begin
      rx_sampling_nxt  = 1'b1;
      rx_bits_left_nxt = RX_DATA_BITS;
      rx_timer_nxt     = {1'b0, bit_period_r} + {2'b00, bit_period_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r    <= BIT_PERIOD_RESET;
      tx_shift_r      <= '0;
      tx_bits_left_r  <= TX_FRAME_BITS;
      tx_timer_r      <= '0;
      tx_level_r      <= 1'b1;
      tx_active_r     <= 1'b0;
      rx_sampling_r   <= 1'b0;
      rx_timer_r      <= '0;
      rx_shift_r      <= '0;
      rx_bits_left_r  <= RX_DATA_BITS;
      rx_prev_level_r <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        bit_period_r <= cfg_wdata;
      end
      if (take) begin
        tx_shift_r      <= tx_shift_nxt;
        tx_bits_left_r  <= tx_bits_left_nxt;
        tx_timer_r      <= tx_timer_nxt;
        tx_level_r      <= tx_level_nxt;
        tx_active_r     <= tx_active_nxt;
        rx_sampling_r   <= rx_sampling_nxt;
        rx_timer_r      <= rx_timer_nxt;
        rx_shift_r      <= rx_shift_nxt;
        rx_bits_left_r  <= rx_bits_left_nxt;
        rx_prev_level_r <= rx_prev_level_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tx_line_r       <= tx_level_nxt;
      tx_busy_r       <= tx_active_nxt;
      send_accepted_r <= accepted_nxt;
      rx_valid_r      <= rx_valid_nxt;
      rx_byte_r       <= rx_byte_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.tx_line       = tx_line_r;
  assign out_if.tx_busy       = tx_busy_r;
  assign out_if.send_accepted = send_accepted_r;
  assign out_if.rx_valid      = rx_valid_r;
  assign out_if.rx_byte       = rx_byte_r;

endmodule

/* src/u8fd_chk.sv */
// Port-level checks for the UART and their bind to the top level.
module u8fd_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              tx_line,
  input logic              tx_busy,
  input logic              send_accepted,
  input logic              rx_valid,
  input u8fd_pkg::byte_t   rx_byte
);
  import u8fd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_accept_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_accepted |-> tx_busy && tx_line)
    else $error("accepted send without busy mark hold");

  a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_busy |-> tx_line)
    else $error("transmit line not at mark while idle");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rx_valid |-> rx_byte == 8'd0)
    else $error("received byte nonzero without valid");

endmodule

bind uart_8n1_full_duplex u8fd_chk u_u8fd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .tx_line       (out_if.tx_line),
  .tx_busy       (out_if.tx_busy),
  .send_accepted (out_if.send_accepted),
  .rx_valid      (out_if.rx_valid),
  .rx_byte       (out_if.rx_byte)
);
